// ===== sv/tcgw_pkg.sv =====
// Shared definitions for the text console glyph writer.
// Holds request, register and command codes, widths and the back-end status struct.
// No dependencies.
package tcgw_pkg;

  localparam int GlyphRows   = 16;
  localparam int RowBits     = 4;
  localparam int CellW       = 8;
  localparam int LineH       = 16;
  localparam int CursorRowW  = 12;
  localparam int RowMax      = 4095;
  localparam int RegW        = 13;
  localparam int CfgDataW    = 32;
  localparam int ColorW      = 32;
  localparam int IndexW      = 24;
  localparam int MaskW       = 8;
  localparam int ReqW        = 2;
  localparam int CharW       = 8;
  localparam int FontAddrW   = 12;
  localparam int FontByteW   = 8;
  localparam int CfgIndexW   = 2;
  localparam int ResetWidth  = 640;
  localparam int ResetStride = 640;
  localparam int QueueDepth  = 2;

  localparam int DefFontChars = 256;
  localparam int DefMaxWidth  = 4096;

  localparam logic [MaskW-1:0]  FullMask = 8'hff;
  localparam logic [ColorW-1:0] ResetFg  = 32'hffff_ffff;

  typedef enum logic [ReqW-1:0] {
    REQ_PUT_CHAR  = 2'd0,
    REQ_BACKSPACE = 2'd1,
    REQ_NEWLINE   = 2'd2,
    REQ_FONT_LOAD = 2'd3
  } req_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_FG_COLOR        = 2'd0,
    REG_CLEAR_COLOR     = 2'd1,
    REG_SCREEN_WIDTH    = 2'd2,
    REG_SCANLINE_STRIDE = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DRAW  = 2'd1,
    OP_ERASE = 2'd2
  } op_e;

  typedef struct packed {
    logic               busy;
    logic [RowBits-1:0] row;
  } bstat_t;

  // Column registers must hold both the saturation limit and the reset width.
  function automatic int col_width(input int max_width);
    int cap;
    cap = (max_width > ResetWidth) ? max_width : ResetWidth;
    return $clog2(cap + 1);
  endfunction

  function automatic int store_addr_width(input int font_chars);
    return $clog2(font_chars * GlyphRows);
  endfunction

endpackage

// ===== sv/text_console_glyph_writer.sv =====
// Text console glyph writer: turns 8x16 one-bit glyphs into framebuffer row writes. A put-char
// or backspace request yields sixteen row writes, one per cycle while not stalled, each
// with a pixel offset (y*stride + x), an eight-pixel mask with bit 7 leftmost and a colour;
// the sixteenth carries last_row. For each cell the back end takes the command from the
// queue, starts the multiply, forms the first offset, then issues the rows, paced by the
// single read port of the glyph memory. A newline only moves the cursor; an in-range font
// load is written when the back end takes it from the queue. A two-entry queue sits
// between request decode and row generation, so requests are taken while rows are still being
// written. The glyph memory is not cleared after reset; every glyph must be loaded before it
// is drawn. Register writes are expected only while no rows are outstanding.
// Depends on tcgw_pkg, tcgw_fifo, tcgw_front and tcgw_back.
module text_console_glyph_writer #(
  parameter int FontChars = tcgw_pkg::DefFontChars,
  parameter int MaxWidth  = tcgw_pkg::DefMaxWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcgw_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tcgw_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tcgw_pkg::ReqW-1:0]      req_type_i,
  input  logic [tcgw_pkg::CharW-1:0]     char_code_i,
  input  logic [tcgw_pkg::FontAddrW-1:0] font_address_i,
  input  logic [tcgw_pkg::FontByteW-1:0] font_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tcgw_pkg::IndexW-1:0]    pixel_index_o,
  output logic [tcgw_pkg::MaskW-1:0]     pixel_mask_o,
  output logic [tcgw_pkg::ColorW-1:0]    pixel_color_o,
  output logic                           last_row_o
);
  import tcgw_pkg::*;

  localparam int ColW = col_width(MaxWidth);
  localparam int AW   = store_addr_width(FontChars);
  localparam int CmdW = 2 + AW + FontByteW + ColW + CursorRowW;

  logic [ColorW-1:0] fg_q, clear_q;
  logic [ColW-1:0]   width_q, stride_q, cfg_sat;
  logic [RegW-1:0]   cfg_v13;
  reg_e              cfg_reg;

  logic            q_push, q_pop, q_full, q_empty;
  logic [CmdW-1:0] q_wdata, q_rdata;
  bstat_t          bstat;

  assign cfg_reg = reg_e'(cfg_index_i);
  assign cfg_v13 = cfg_data_i[RegW-1:0];
  assign cfg_sat = (cfg_v13 > RegW'(MaxWidth)) ? ColW'(MaxWidth) : ColW'(cfg_v13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q     <= ResetFg;
      clear_q  <= '0;
      width_q  <= ColW'(ResetWidth);
      stride_q <= ColW'(ResetStride);
    end else if (cfg_we_i) begin
      unique case (cfg_reg)
        REG_FG_COLOR:        fg_q     <= cfg_data_i;
        REG_CLEAR_COLOR:     clear_q  <= cfg_data_i;
        REG_SCREEN_WIDTH:    width_q  <= cfg_sat;
        REG_SCANLINE_STRIDE: stride_q <= cfg_sat;
        default:             fg_q     <= fg_q;
      endcase
    end
  end

  tcgw_front #(
    .FontChars(FontChars),
    .MaxWidth (MaxWidth),
    .ColW     (ColW),
    .CmdW     (CmdW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .char_code_i   (char_code_i),
    .font_address_i(font_address_i),
    .font_byte_i   (font_byte_i),
    .screen_width_i(width_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  tcgw_fifo #(
    .Width(CmdW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  tcgw_back #(
    .FontChars(FontChars),
    .MaxWidth (MaxWidth),
    .ColW     (ColW),
    .CmdW     (CmdW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_data_i     (q_rdata),
    .stride_i     (stride_q),
    .fg_color_i   (fg_q),
    .clear_color_i(clear_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .pixel_index_o(pixel_index_o),
    .pixel_mask_o (pixel_mask_o),
    .pixel_color_o(pixel_color_o),
    .last_row_o   (last_row_o),
    .status_o     (bstat)
  );

  // While a row other than the last is waiting, the rest of the cell is still being generated.
  a_cell_in_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_row_o |-> bstat.busy)
    else $error("row write pending without an active cell");

  // A stalled row write keeps its offset and its place in the cell.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_index_o) && $stable(last_row_o))
    else $error("stalled row write changed");

  // The row counter rests at zero between cells.
  a_counter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bstat.busy && !$past(bstat.busy) |-> bstat.row == '0)
    else $error("row counter moved while no cell was active");

endmodule

// ===== sv/tcgw_fifo.sv =====
// Short command queue between the front end and the back end.
// Generic width; depth from tcgw_pkg.
module tcgw_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/tcgw_front.sv =====
// Front end: accepts requests, keeps the text cursor and queues draw, erase and load commands.
// Depends on tcgw_pkg.
module tcgw_front #(
  parameter int FontChars = tcgw_pkg::DefFontChars,
  parameter int MaxWidth  = tcgw_pkg::DefMaxWidth,
  parameter int ColW      = tcgw_pkg::col_width(MaxWidth),
  parameter int CmdW      = 2 + tcgw_pkg::store_addr_width(FontChars) + tcgw_pkg::FontByteW
                            + ColW + tcgw_pkg::CursorRowW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tcgw_pkg::ReqW-1:0]      req_type_i,
  input  logic [tcgw_pkg::CharW-1:0]     char_code_i,
  input  logic [tcgw_pkg::FontAddrW-1:0] font_address_i,
  input  logic [tcgw_pkg::FontByteW-1:0] font_byte_i,
  input  logic [ColW-1:0]                screen_width_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output logic [CmdW-1:0]                q_data_o
);
  import tcgw_pkg::*;

  localparam int AW         = store_addr_width(FontChars);
  localparam int CharIdxW   = AW - RowBits;
  localparam int StoreDepth = FontChars * GlyphRows;
  localparam int ChrExtW    = 10;

  logic [ColW-1:0]       col_q, col_d;
  logic [CursorRowW-1:0] row_q, row_d;
  logic                  accept;
  req_e                  req;

  logic [ColW:0]         col_p8, col_p16;
  logic [ColW-1:0]       bs_col, bs_x;
  logic [CursorRowW-1:0] bs_row;
  logic                  bs_ge8;
  logic [ChrExtW-1:0]    chr_ext, chr_mod;
  logic [AW+FontAddrW-1:0] addr_ext;
  logic                  load_ok;
  op_e                   cmd_op;
  logic [AW-1:0]         cmd_addr;
  logic [ColW-1:0]       cmd_x;
  logic [CursorRowW-1:0] cmd_y;

  function automatic logic [CursorRowW-1:0] row_down(input logic [CursorRowW-1:0] r);
    return (r > CursorRowW'(RowMax - LineH)) ? CursorRowW'(RowMax) : r + CursorRowW'(LineH);
  endfunction

  function automatic logic [CursorRowW-1:0] row_up(input logic [CursorRowW-1:0] r);
    return (r >= CursorRowW'(LineH)) ? r - CursorRowW'(LineH) : '0;
  endfunction

  assign req        = req_e'(req_type_i);
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign col_p8  = (ColW + 1)'(col_q) + (ColW + 1)'(CellW);
  assign col_p16 = col_p8 + (ColW + 1)'(CellW);

  // Backspace at column zero first steps back to the end of the previous line.
  assign bs_col = (col_q == '0) ? screen_width_i : col_q;
  assign bs_row = (col_q == '0) ? row_up(row_q) : row_q;
  assign bs_ge8 = (bs_col >= ColW'(CellW));
  assign bs_x   = bs_ge8 ? bs_col - ColW'(CellW) : '0;

  // For FontChars >= 128 codes stay below twice the font size; one conditional subtract reduces them.
  assign chr_ext = ChrExtW'(char_code_i);
  assign chr_mod = (chr_ext >= ChrExtW'(FontChars)) ? chr_ext - ChrExtW'(FontChars) : chr_ext;

  assign addr_ext = (AW + FontAddrW)'(font_address_i);
  assign load_ok  = (addr_ext < (AW + FontAddrW)'(StoreDepth));

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    cmd_op   = OP_DRAW;
    cmd_addr = {chr_mod[CharIdxW-1:0], RowBits'(0)};
    cmd_x    = col_q;
    cmd_y    = row_q;
    q_push_o = 1'b0;
    unique case (req)
      REQ_PUT_CHAR: begin
        q_push_o = accept;
        if (col_p16 > (ColW + 1)'(screen_width_i)) begin
          col_d = '0;
          row_d = row_down(row_q);
        end else begin
          col_d = col_p8[ColW-1:0];
        end
      end
      REQ_BACKSPACE: begin
        q_push_o = accept;
        cmd_op   = OP_ERASE;
        cmd_x    = bs_x;
        cmd_y    = bs_row;
        if (bs_ge8) begin
          col_d = bs_x;
          row_d = bs_row;
        end else begin
          col_d = screen_width_i;
          row_d = row_up(bs_row);
        end
      end
      REQ_NEWLINE: begin
        col_d = '0;
        row_d = row_down(row_q);
      end
      REQ_FONT_LOAD: begin
        q_push_o = accept && load_ok;
        cmd_op   = OP_LOAD;
        cmd_addr = addr_ext[AW-1:0];
      end
      default: begin
        col_d = col_q;
      end
    endcase
  end

  assign q_data_o = {cmd_op, cmd_addr, font_byte_i, cmd_x, cmd_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== sv/tcgw_back.sv =====
// Back end: holds the glyph memory and turns queued commands into row writes.
// Depends on tcgw_pkg.
module tcgw_back #(
  parameter int FontChars = tcgw_pkg::DefFontChars,
  parameter int MaxWidth  = tcgw_pkg::DefMaxWidth,
  parameter int ColW      = tcgw_pkg::col_width(MaxWidth),
  parameter int CmdW      = 2 + tcgw_pkg::store_addr_width(FontChars) + tcgw_pkg::FontByteW
                            + ColW + tcgw_pkg::CursorRowW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  logic [CmdW-1:0]             q_data_i,
  input  logic [ColW-1:0]             stride_i,
  input  logic [tcgw_pkg::ColorW-1:0] fg_color_i,
  input  logic [tcgw_pkg::ColorW-1:0] clear_color_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [tcgw_pkg::IndexW-1:0] pixel_index_o,
  output logic [tcgw_pkg::MaskW-1:0]  pixel_mask_o,
  output logic [tcgw_pkg::ColorW-1:0] pixel_color_o,
  output logic                        last_row_o,
  output tcgw_pkg::bstat_t            status_o
);
  import tcgw_pkg::*;

  localparam int AW         = store_addr_width(FontChars);
  localparam int StoreDepth = FontChars * GlyphRows;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [MaskW-1:0] glyph_mem [StoreDepth];

  logic [1:0]            c_op_raw;
  op_e                   c_op;
  logic [AW-1:0]         c_addr;
  logic [FontByteW-1:0]  c_byte;
  logic [ColW-1:0]       c_x;
  logic [CursorRowW-1:0] c_y;

  logic [1:0]         state_q;
  logic [RowBits-1:0] cnt_q;
  logic [AW-1:0]      base_q;
  logic [ColW-1:0]    x_q;
  logic [IndexW-1:0]  prod_q, idx_q;
  logic               erase_q;
  logic               out_valid_q, out_last_q, out_erase_q;
  logic [IndexW-1:0]  out_index_q;
  logic [MaskW-1:0]   rdata_q;
  logic               adv, issue, mem_we, last_cnt;

  assign {c_op_raw, c_addr, c_byte, c_x, c_y} = q_data_i;
  assign c_op = op_e'(c_op_raw);

  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign mem_we   = q_pop_o && (c_op == OP_LOAD);
  assign adv      = !out_valid_q || !out_stall_i;
  assign issue    = (state_q == ST_RUN) && adv;
  assign last_cnt = (cnt_q == RowBits'(GlyphRows - 1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem[c_addr] <= c_byte;
    end
    if (issue) begin
      rdata_q <= glyph_mem[base_q + AW'(cnt_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= issue;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_pop_o && (c_op != OP_LOAD)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_RUN;
          cnt_q   <= '0;
        end
        ST_RUN: begin
          if (issue) begin
            cnt_q <= cnt_q + RowBits'(1);
            if (last_cnt) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The first row offset takes one multiply; later rows step by the stride.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      base_q  <= c_addr;
      x_q     <= c_x;
      erase_q <= (c_op == OP_ERASE);
      prod_q  <= IndexW'(c_y) * IndexW'(stride_i);
    end
    if (state_q == ST_MUL) begin
      idx_q <= prod_q + IndexW'(x_q);
    end else if (issue) begin
      idx_q <= idx_q + IndexW'(stride_i);
    end
    if (issue) begin
      out_index_q <= idx_q;
      out_last_q  <= last_cnt;
      out_erase_q <= erase_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_index_q;
  assign pixel_mask_o  = out_erase_q ? FullMask : rdata_q;
  assign pixel_color_o = out_erase_q ? clear_color_i : fg_color_i;
  assign last_row_o    = out_last_q;

  assign status_o.busy = (state_q != ST_IDLE);
  assign status_o.row  = cnt_q;

endmodule
